### rtl/core/h2r_pkg.sv
package h2r_pkg;

  // Fixed-point formats of the ports.
  localparam int HUE_FRACTION_BITS   = 4;
  localparam int LEVEL_FRACTION_BITS = 14;
  localparam int LEVEL_ONE           = 1 << LEVEL_FRACTION_BITS;
  localparam int LEVEL_W             = LEVEL_FRACTION_BITS + 1;

  // Hue span of one sector (60 degrees) and a bias of six whole turns that
  // lifts any 16-bit hue to a non-negative value.
  localparam int SECTOR_SPAN = 60 << HUE_FRACTION_BITS;
  localparam int HUE_BIAS    = 6 * (360 << HUE_FRACTION_BITS);

  // Reciprocal multipliers: floor(w/15) = (w*4370) >> 16 for w < 1100 and
  // floor(q/6) = (q*43) >> 8 for q < 80.
  localparam int RECIP_15 = 4370;
  localparam int RECIP_6  = 43;

  // Sector codes, named by the hue range they cover.
  localparam logic [2:0] SEC_RED_YELLOW    = 3'd0;
  localparam logic [2:0] SEC_YELLOW_GREEN  = 3'd1;
  localparam logic [2:0] SEC_GREEN_CYAN    = 3'd2;
  localparam logic [2:0] SEC_CYAN_BLUE     = 3'd3;
  localparam logic [2:0] SEC_BLUE_MAGENTA  = 3'd4;
  localparam logic [2:0] SEC_MAGENTA_RED   = 3'd5;

  // Beat from the hue splitter to the chroma stages.
  typedef struct packed {
    logic [2:0]         sector;
    logic [9:0]         k;
    logic [28:0]        vs;
    logic [LEVEL_W-1:0] v;
  } h2r_split_t;

  // Beat from the chroma stages to the output stage. Each level is a channel
  // value scaled by 960 * 2^28.
  typedef struct packed {
    logic [2:0]  sector;
    logic [37:0] yc;
    logic [37:0] yx;
    logic [37:0] ym;
  } h2r_level_t;

endpackage

### rtl/core/h2r_split.sv
module h2r_split
  import h2r_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic [15:0]  hue,
  input  logic [15:0]  saturation,
  input  logic [15:0]  brightness,
  output logic         dn_valid,
  input  logic         dn_ready,
  output h2r_split_t   dn_data
);

  // Clamps a signed level into 0..1.0.
  function automatic logic [LEVEL_W-1:0] clamp_level(input logic [15:0] raw);
    logic [LEVEL_W-1:0] res;
    if (raw[15]) begin
      res = '0;
    end else if (raw > 16'(LEVEL_ONE)) begin
      res = LEVEL_W'(LEVEL_ONE);
    end else begin
      res = raw[LEVEL_W-1:0];
    end
    return res;
  endfunction

  logic               s1_valid;
  logic [6:0]         s1_q;
  logic [10:0]        s1_w;
  logic [5:0]         s1_lo;
  logic [LEVEL_W-1:0] s1_s;
  logic [LEVEL_W-1:0] s1_v;
  logic               s1_ready;
  logic               s2_ready;

  logic [17:0] hue_sum;
  logic [10:0] hue_w;
  logic [23:0] q_prod;

  logic [10:0] r_diff;
  logic [11:0] q6_prod;
  logic [6:0]  sec_diff;
  logic [9:0]  rem;
  logic [2:0]  sector;
  logic [9:0]  k;
  logic [29:0] vs_full;

  assign s1_ready = !s1_valid || s2_ready;
  assign s2_ready = !dn_valid || dn_ready;
  assign in_ready = s1_ready;

  // Stage 1: bias the hue to a non-negative count and divide it by 960 as
  // a shift by six and a reciprocal multiply by fifteen.
  assign hue_sum = {{2{hue[15]}}, hue} + 18'(HUE_BIAS);
  assign hue_w   = hue_sum[16:6];
  assign q_prod  = 24'(hue_w) * 24'(RECIP_15);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && in_valid) begin
      s1_q  <= q_prod[22:16];
      s1_w  <= hue_w;
      s1_lo <= hue_sum[5:0];
      s1_s  <= clamp_level(saturation);
      s1_v  <= clamp_level(brightness);
    end
  end

  // Stage 2: remainder within the sector, sector number modulo six,
  // distance from the sector start (even) or end (odd), and chroma v*s.
  assign r_diff   = s1_w - 11'(s1_q) * 11'd15;
  assign rem      = {r_diff[3:0], s1_lo};
  assign q6_prod  = 12'(s1_q) * 12'(RECIP_6);
  assign sec_diff = s1_q - 7'(q6_prod[11:8]) * 7'd6;
  assign sector   = sec_diff[2:0];
  assign k        = sector[0] ? (10'(SECTOR_SPAN) - rem) : rem;
  assign vs_full  = 30'(s1_v) * 30'(s1_s);

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (s2_ready) begin
      dn_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && s1_valid) begin
      dn_data.sector <= sector;
      dn_data.k      <= k;
      dn_data.vs     <= vs_full[28:0];
      dn_data.v      <= s1_v;
    end
  end

  // The sector number and the remainder stay in range.
  a_sector_range: assert property (@(posedge clk) disable iff (rst)
    s1_valid |-> (sector <= SEC_MAGENTA_RED) && (rem < 10'(SECTOR_SPAN)))
    else $error("hue split out of range");

endmodule

### rtl/core/h2r_chroma.sv
module h2r_chroma
  import h2r_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        up_valid,
  output logic        up_ready,
  input  h2r_split_t  up_data,
  output logic        dn_valid,
  input  logic        dn_ready,
  output h2r_level_t  dn_data
);

  logic               s3_valid;
  logic [2:0]         s3_sector;
  logic [37:0]        s3_xv;
  logic [37:0]        s3_mb;
  logic [LEVEL_W-1:0] s3_v;
  logic               s3_ready;
  logic               s4_ready;

  logic [28:0] base_diff;
  logic [38:0] xv_full;
  logic [38:0] mb_full;
  logic [24:0] yc_prod;

  assign s3_ready = !s3_valid || s4_ready;
  assign s4_ready = !dn_valid || dn_ready;
  assign up_ready = s3_ready;

  // Stage 3: the x term k*vs and the floor term 960*(v - v*s).
  assign base_diff = {up_data.v, LEVEL_FRACTION_BITS'(0)} - up_data.vs;
  assign xv_full   = 39'(up_data.k) * 39'(up_data.vs);
  assign mb_full   = 39'(base_diff) * 39'(SECTOR_SPAN);

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (s3_ready) begin
      s3_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_ready && up_valid) begin
      s3_sector <= up_data.sector;
      s3_xv     <= xv_full[37:0];
      s3_mb     <= mb_full[37:0];
      s3_v      <= up_data.v;
    end
  end

  // Stage 4: the three channel levels, top (c + m), middle (x + m), floor (m).
  assign yc_prod = 25'(s3_v) * 25'(SECTOR_SPAN);

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (s4_ready) begin
      dn_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s4_ready && s3_valid) begin
      dn_data.sector <= s3_sector;
      dn_data.yc     <= {yc_prod[23:0], LEVEL_FRACTION_BITS'(0)};
      dn_data.yx     <= s3_mb + s3_xv;
      dn_data.ym     <= s3_mb;
    end
  end

  // The edge distance never exceeds one sector span.
  a_k_range: assert property (@(posedge clk) disable iff (rst)
    up_valid |-> (up_data.k <= 10'(SECTOR_SPAN)))
    else $error("edge distance exceeds sector span");

endmodule

### rtl/core/h2r_pack.sv
module h2r_pack
  import h2r_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        up_valid,
  output logic        up_ready,
  input  h2r_level_t  up_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  red,
  output logic [7:0]  green,
  output logic [7:0]  blue
);

  // Scales a level by 255 / (960 * 2^28) and rounds half up; 255/960 is
  // 17/64, so this is (17*y + 2^33) >> 34.
  function automatic logic [7:0] to_byte(input logic [37:0] y);
    logic [42:0] t;
    t = {1'b0, y, 4'b0000} + 43'(y) + (43'd1 << 33);
    return t[41:34];
  endfunction

  logic [7:0] byte_c;
  logic [7:0] byte_x;
  logic [7:0] byte_m;
  logic [7:0] red_next;
  logic [7:0] green_next;
  logic [7:0] blue_next;

  assign up_ready = !out_valid || !out_stall;

  assign byte_c = to_byte(up_data.yc);
  assign byte_x = to_byte(up_data.yx);
  assign byte_m = to_byte(up_data.ym);

  // Place the three levels by sector.
  always_comb begin
    case (up_data.sector)
      SEC_RED_YELLOW: begin
        red_next = byte_c; green_next = byte_x; blue_next = byte_m;
      end
      SEC_YELLOW_GREEN: begin
        red_next = byte_x; green_next = byte_c; blue_next = byte_m;
      end
      SEC_GREEN_CYAN: begin
        red_next = byte_m; green_next = byte_c; blue_next = byte_x;
      end
      SEC_CYAN_BLUE: begin
        red_next = byte_m; green_next = byte_x; blue_next = byte_c;
      end
      SEC_BLUE_MAGENTA: begin
        red_next = byte_x; green_next = byte_m; blue_next = byte_c;
      end
      default: begin
        red_next = byte_c; green_next = byte_m; blue_next = byte_x;
      end
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (up_ready) begin
      out_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      red   <= red_next;
      green <= green_next;
      blue  <= blue_next;
    end
  end

  // The top channel is never below the middle one, nor the middle below the floor.
  a_level_order: assert property (@(posedge clk) disable iff (rst)
    up_valid |-> (byte_c >= byte_x) && (byte_x >= byte_m))
    else $error("channel levels out of order");

endmodule

### rtl/core/hsv_to_rgb_converter.sv
//  Channel  Handshake             Fields (bits)
//  input    in_valid / in_stall   hue (16 s), saturation (16 s), brightness (16 s)
//  output   out_valid / out_stall red (8), green (8), blue (8)
//
//  One beat enters per cycle while in_stall is low.
//  The five register stages are: hue split, sector and chroma, x and floor
//  products, channel levels, rounding and output register.
//  Reset clears only the stage valid bits; the block keeps no other state.
//  A stall on the output holds every full stage; bubbles still close up.
module hsv_to_rgb_converter
  import h2r_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] hue,
  input  logic [15:0] saturation,
  input  logic [15:0] brightness,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  red,
  output logic [7:0]  green,
  output logic [7:0]  blue
);

  logic       in_ready;
  logic       split_valid;
  logic       split_ready;
  h2r_split_t split_data;
  logic       level_valid;
  logic       level_ready;
  h2r_level_t level_data;

  assign in_stall = !in_ready;

  // Hue sector, edge distance and chroma.
  h2r_split u_split (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .hue        (hue),
    .saturation (saturation),
    .brightness (brightness),
    .dn_valid   (split_valid),
    .dn_ready   (split_ready),
    .dn_data    (split_data)
  );

  // Channel levels.
  h2r_chroma u_chroma (
    .clk      (clk),
    .rst      (rst),
    .up_valid (split_valid),
    .up_ready (split_ready),
    .up_data  (split_data),
    .dn_valid (level_valid),
    .dn_ready (level_ready),
    .dn_data  (level_data)
  );

  // Rounding, channel placement and output register.
  h2r_pack u_pack (
    .clk       (clk),
    .rst       (rst),
    .up_valid  (level_valid),
    .up_ready  (level_ready),
    .up_data   (level_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .red       (red),
    .green     (green),
    .blue      (blue)
  );

  // The input is held off only when the whole pipe is full behind a stalled output.
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall && split_valid && level_valid)
    else $error("input stalled with room in the pipeline");

endmodule
